/* sv/hobd_pkg.sv */
// ============================================================================
// hobd_pkg
// shared types, constants and a three-value sort helper for the outlier bin detector
// ============================================================================
package hobd_pkg;

    localparam int CNT_W  = 16;
    localparam int TOT_W  = 32;
    localparam int DIM_W  = 9;
    localparam int THR_W  = 17;
    localparam int CRD_W  = 8;
    localparam int IDX_W  = 2;
    localparam int CFG_W  = 17;

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_THRESH = 2'd2;

    typedef logic [CNT_W-1:0] t_cnt;

    // per-result side data carried down the median pipe
    typedef struct packed {
        logic             last;
        logic [CRD_W-1:0] bin_x;
        logic [CRD_W-1:0] bin_y;
        logic             miss_t;
        logic             miss_b;
        logic             miss_l;
        logic             miss_r;
        t_cnt             hval;
    } t_meta;

    typedef struct packed {
        logic [CRD_W-1:0] bin_x;
        logic [CRD_W-1:0] bin_y;
        logic             is_outlier;
        t_cnt             outlier_count;
        logic [TOT_W-1:0] running_total;
        logic             last_bin;
    } t_result;

    typedef struct packed {
        t_cnt lo;
        t_cnt mi;
        t_cnt hi;
    } t_tri;

    function automatic t_tri sort3(input t_cnt a, input t_cnt b, input t_cnt c);
        t_cnt x1, y1, m1;
        t_tri s;
        x1   = (a < b) ? a : b;
        y1   = (a < b) ? b : a;
        m1   = (y1 < c) ? y1 : c;
        s.hi = (y1 < c) ? c : y1;
        s.lo = (x1 < m1) ? x1 : m1;
        s.mi = (x1 < m1) ? m1 : x1;
        return s;
    endfunction

endpackage

/* sv/hobd_if.sv */
// ============================================================================
// hobd channel interfaces
// input, result and configuration channels with valid/ready handshake
// ============================================================================
interface hobd_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] bin_count;
    modport source (output valid, output action, output bin_count, input ready);
    modport sink   (input valid, input action, input bin_count, output ready);
endinterface

interface hobd_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  bin_x;
    logic [7:0]  bin_y;
    logic        is_outlier;
    logic [15:0] outlier_count;
    logic [31:0] running_total;
    logic        last_bin;
    modport source (output valid, output bin_x, output bin_y, output is_outlier,
                    output outlier_count, output running_total, output last_bin,
                    input ready);
    modport sink   (input valid, input bin_x, input bin_y, input is_outlier,
                    input outlier_count, input running_total, input last_bin,
                    output ready);
endinterface

interface hobd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/hobd_line_store.sv */
// ============================================================================
// hobd_line_store
// two line memories, read through a register, rotated and written back with forwarding
// ============================================================================
module hobd_line_store
    import hobd_pkg::*;
#(
    parameter int MAX_WIDTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_addr,
    input  t_cnt                         i_val,
    output logic                         o_valid,
    output t_cnt                         o_up,
    output t_cnt                         o_mid,
    output t_cnt                         o_val
);
    localparam int AW = $clog2(MAX_WIDTH);

    t_cnt upper_mem  [MAX_WIDTH];
    t_cnt middle_mem [MAX_WIDTH];

    logic          r_valid;
    logic [AW-1:0] r_addr;
    t_cnt          r_val;
    t_cnt          r_up_q;
    t_cnt          r_mid_q;
    logic          r_fwd;
    t_cnt          r_fwd_up;
    t_cnt          r_fwd_mid;
    t_cnt          eff_up;
    t_cnt          eff_mid;

    // back-to-back hit on one entry: the write lands at the same edge as the read
    assign eff_up  = r_fwd ? r_fwd_up  : r_up_q;
    assign eff_mid = r_fwd ? r_fwd_mid : r_mid_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_fwd <= r_valid && (r_addr == i_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_addr    <= i_addr;
            r_val     <= i_val;
            r_up_q    <= upper_mem[i_addr];
            r_mid_q   <= middle_mem[i_addr];
            r_fwd_up  <= eff_mid;
            r_fwd_mid <= r_val;
        end
        if (r_valid) begin
            upper_mem[r_addr]  <= eff_mid;
            middle_mem[r_addr] <= r_val;
        end
    end

    assign o_valid = r_valid;
    assign o_up    = eff_up;
    assign o_mid   = eff_mid;
    assign o_val   = r_val;

endmodule

/* sv/hobd_median9.sv */
// ============================================================================
// hobd_median9
// three-stage median of nine: column sort, row reduce, final median of three
// ============================================================================
module hobd_median9
    import hobd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_meta i_meta,
    input  t_cnt  i_vals [9],
    output logic  o_valid,
    output t_meta o_meta,
    output t_cnt  o_med
);
    logic  r_va, r_vb, r_vc;
    t_meta r_ma, r_mb, r_mc;
    t_tri  r_col [3];
    t_cnt  r_b [3];
    t_cnt  r_med;
    t_tri  n_col [3];
    t_tri  t_lo, t_mi, t_hi;
    t_tri  t_fin;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_col[k] = sort3(i_vals[k], i_vals[3+k], i_vals[6+k]);
        end
        t_lo  = sort3(r_col[0].lo, r_col[1].lo, r_col[2].lo);
        t_mi  = sort3(r_col[0].mi, r_col[1].mi, r_col[2].mi);
        t_hi  = sort3(r_col[0].hi, r_col[1].hi, r_col[2].hi);
        t_fin = sort3(r_b[0], r_b[1], r_b[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ma  <= i_meta;
        r_col <= n_col;
        r_mb  <= r_ma;
        r_b[0] <= t_lo.hi;
        r_b[1] <= t_mi.mi;
        r_b[2] <= t_hi.lo;
        r_mc  <= r_mb;
        r_med <= t_fin.mi;
    end

    assign o_valid = r_vc;
    assign o_meta  = r_mc;
    assign o_med   = r_med;

endmodule

/* sv/hobd_out_fifo.sv */
// ============================================================================
// hobd_out_fifo
// result queue that decouples the fixed-latency pipe from output stalls
// ============================================================================
module hobd_out_fifo
    import hobd_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_result       i_data,
    output logic          o_pop,
    hobd_out_if.source    o_out
);
    localparam int AW = $clog2(DEPTH);

    t_result        r_buf [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_num;
    t_result        head;
    logic           pop;

    assign head = r_buf[r_rd];
    assign pop  = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_num <= r_num + (AW+1)'(i_push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_data;
        end
    end

    assign o_pop               = pop;
    assign o_out.valid         = (r_num != '0);
    assign o_out.bin_x         = head.bin_x;
    assign o_out.bin_y         = head.bin_y;
    assign o_out.is_outlier    = head.is_outlier;
    assign o_out.outlier_count = head.outlier_count;
    assign o_out.running_total = head.running_total;
    assign o_out.last_bin      = head.last_bin;

endmodule

/* sv/histogram_outlier_bin_detector_unit.sv */
// ============================================================================
// histogram_outlier_bin_detector_unit
// 3x3 median outlier test over histogram bins streamed in raster order
// ============================================================================
// throughput: one word per cycle on the input while result queue slots are free,
//   one result per cycle on the output while the receiver is ready
// a result passes the memory read, window, edge fill, median and queue registers
// results trail the input by image_width + 1 words; flush words drain the tail
// reset clears positions, window, total and the result queue; the line
//   memories are not cleared and need no clearing pass
module histogram_outlier_bin_detector_unit
    import hobd_pkg::*;
#(
    parameter int MAX_WIDTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hobd_in_if.sink    i_in,
    hobd_cfg_if.sink   i_cfg,
    hobd_out_if.source o_out
);
    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int QD    = 16;
    localparam int QW    = $clog2(QD) + 1;
    localparam int NW    = 2 * DIM_W;

    // configuration registers
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic [THR_W-1:0] r_thresh;

    // stream position (front end owns all sequencing)
    logic [DIM_W-1:0] r_col;
    logic [NW-1:0]    r_pos;
    logic [DIM_W-1:0] r_ox;
    logic [DIM_W-1:0] r_oy;
    logic [QW-1:0]    r_used;
    logic [TOT_W-1:0] r_total;

    // effective sizes
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [NW-1:0]    n_bins;
    logic [NW-1:0]    w_ext;

    logic             acc;
    logic             beyond;
    logic             ignore;
    logic             act;
    logic             emit;
    logic             last;
    t_cnt             v_in;
    t_meta            meta0;
    logic             size_wr;

    always_comb begin
        w_eff = r_width;
        if (r_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        h_eff = r_height;
        if (r_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (r_height > DIM_W'(256)) begin
            h_eff = DIM_W'(256);
        end
    end

    assign w_ext  = NW'(w_eff);
    assign n_bins = NW'(w_eff) * NW'(h_eff);

    // a flush word before the frame is complete is dropped; after it, any word flushes
    assign beyond = (r_pos >= n_bins);
    assign ignore = !beyond && i_in.action;
    assign emit   = (r_pos >= w_ext + NW'(1));
    assign last   = (r_pos == n_bins + w_ext);
    assign v_in   = beyond ? '0 : i_in.bin_count;

    assign i_in.ready  = (r_used < QW'(QD));
    assign acc         = i_in.valid && i_in.ready;
    assign act         = acc && !ignore;
    assign i_cfg.ready = 1'b1;
    assign size_wr     = i_cfg.valid &&
                         ((i_cfg.index == CFG_WIDTH) || (i_cfg.index == CFG_HEIGHT));

    // edge flags for the bin being decided
    always_comb begin
        meta0        = '0;
        meta0.last   = last;
        meta0.bin_x  = r_ox[CRD_W-1:0];
        meta0.bin_y  = r_oy[CRD_W-1:0];
        meta0.miss_t = (r_oy == '0);
        meta0.miss_b = (r_oy + DIM_W'(1) >= h_eff);
        meta0.miss_l = (r_ox == '0);
        meta0.miss_r = (r_ox + DIM_W'(1) >= w_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_W'(256);
            r_height <= DIM_W'(256);
            r_thresh <= THR_W'(655);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WIDTH:  r_width  <= i_cfg.data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg.data[DIM_W-1:0];
                CFG_THRESH: r_thresh <= i_cfg.data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_col <= '0;
            r_pos <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (act) begin
            if (emit && last) begin
                r_col <= '0;
                r_pos <= '0;
                r_ox  <= '0;
                r_oy  <= '0;
            end else begin
                r_pos <= r_pos + NW'(1);
                r_col <= (r_col + DIM_W'(1) >= w_eff) ? '0 : r_col + DIM_W'(1);
                if (emit) begin
                    if (r_ox + DIM_W'(1) >= w_eff) begin
                        r_ox <= '0;
                        r_oy <= r_oy + DIM_W'(1);
                    end else begin
                        r_ox <= r_ox + DIM_W'(1);
                    end
                end
            end
        end
    end

    // line memories
    logic ls_valid;
    t_cnt ls_up, ls_mid, ls_val;

    hobd_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (act),
        .i_addr  (AW'(r_col)),
        .i_val   (v_in),
        .o_valid (ls_valid),
        .o_up    (ls_up),
        .o_mid   (ls_mid),
        .o_val   (ls_val)
    );

    logic  r_s1_emit;
    t_meta r_s1_meta;
    logic  r_s2_v;
    t_meta r_s2_meta;
    t_cnt  r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (act) begin
            r_s1_emit <= emit;
            r_s1_meta <= meta0;
        end
        r_s2_meta <= r_s1_meta;
    end

    // window shifts once per word that reaches the line memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else begin
            r_s2_v <= ls_valid && r_s1_emit;
            if (ls_valid) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= ls_up;
                r_win[1][2] <= ls_mid;
                r_win[2][2] <= ls_val;
            end
        end
    end

    // out-of-bounds neighbours become zeros and full-scale values in a mix that
    // keeps the upper middle of the in-bounds values at the center of nine
    logic        r_s3_v;
    t_meta       r_s3_meta;
    t_cnt        r_s3_vals [9];
    t_cnt        fill [9];
    t_meta       meta2;
    logic [1:0]  rows_in;
    logic [1:0]  cols_in;
    logic [3:0]  cnt_in;
    logic [3:0]  lows;
    logic [3:0]  miss_n;
    logic        gone;

    always_comb begin
        rows_in = 2'd3 - 2'(r_s2_meta.miss_t) - 2'(r_s2_meta.miss_b);
        cols_in = 2'd3 - 2'(r_s2_meta.miss_l) - 2'(r_s2_meta.miss_r);
        cnt_in  = 4'(rows_in) * 4'(cols_in);
        lows    = 4'd4 - (cnt_in >> 1);
        miss_n  = '0;
        gone    = 1'b0;
        for (int p = 0; p < 9; p++) begin
            gone = ((p / 3 == 0) && r_s2_meta.miss_t) || ((p / 3 == 2) && r_s2_meta.miss_b) ||
                   ((p % 3 == 0) && r_s2_meta.miss_l) || ((p % 3 == 2) && r_s2_meta.miss_r);
            fill[p] = r_win[p / 3][p % 3];
            if (gone) begin
                fill[p] = (miss_n < lows) ? '0 : '1;
                miss_n  = miss_n + 4'd1;
            end
        end
        meta2      = r_s2_meta;
        meta2.hval = r_win[1][1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_meta <= meta2;
        r_s3_vals <= fill;
    end

    logic  md_valid;
    t_meta md_meta;
    t_cnt  md_med;

    hobd_median9 u_median (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_v),
        .i_meta  (r_s3_meta),
        .i_vals  (r_s3_vals),
        .o_valid (md_valid),
        .o_meta  (md_meta),
        .o_med   (md_med)
    );

    // decision and saturating total
    logic             outlier;
    t_cnt             contrib;
    logic [TOT_W:0]   sum_ext;
    logic [TOT_W-1:0] tot_next;
    t_result          res;

    always_comb begin
        outlier  = (THR_W'(md_meta.hval) < r_thresh) && (md_meta.hval > md_med);
        contrib  = outlier ? md_meta.hval : '0;
        sum_ext  = {1'b0, r_total} + (TOT_W+1)'(contrib);
        tot_next = sum_ext[TOT_W] ? '1 : sum_ext[TOT_W-1:0];
        res.bin_x         = md_meta.bin_x;
        res.bin_y         = md_meta.bin_y;
        res.is_outlier    = outlier;
        res.outlier_count = contrib;
        res.running_total = tot_next;
        res.last_bin      = md_meta.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || size_wr) begin
            r_total <= '0;
        end else if (md_valid) begin
            r_total <= md_meta.last ? '0 : tot_next;
        end
    end

    logic q_pop;

    hobd_out_fifo #(
        .DEPTH (QD)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (md_valid),
        .i_data  (res),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

    // queue slots held by results in flight or waiting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + QW'(act && emit) - QW'(q_pop);
        end
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= QW'(QD))
        else $error("result credit overrun");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= n_bins + w_ext)
        else $error("stream position past frame end");

    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        act && emit && last |=> (r_pos == '0) && (r_ox == '0) && (r_oy == '0))
        else $error("position not cleared after final bin");

    a_last_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_valid && md_meta.last |=> (r_total == '0))
        else $error("running total not cleared after final bin");

endmodule

/* tb/sv/histogram_outlier_bin_detector_unit_test.sv */
// ============================================================================
// histogram_outlier_bin_detector_unit_test
// streams whole histograms of many sizes and thresholds through the detector,
// predicts each bin's 3x3 median outlier decision and running total, and
// checks every result word in order under random stalls on both channels
// ============================================================================
module histogram_outlier_bin_detector_unit_test;
    import hobd_pkg::*;

    localparam bit ACT_BIN   = 1'b0;
    localparam bit ACT_FLUSH = 1'b1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_GAP   = 16;   // covers the result latency

    typedef struct {
        bit          action;
        bit [15:0]   count;
    } bin_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    hobd_in_if  in_ch ();
    hobd_out_if out_ch ();
    hobd_cfg_if cfg_ch ();

    histogram_outlier_bin_detector_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // words waiting to be sent and results still owed by the block
    bin_word_t   pending_words[$];
    t_result     owed_results[$];
    bin_word_t   word_on_bus;
    t_result     decided;

    // predictor copy of the block state
    logic [15:0] upper_mem [256];
    logic [15:0] middle_mem [256];
    logic [15:0] win [3][3];
    int unsigned in_col, in_row, out_idx;
    logic [31:0] outlier_sum;
    int unsigned width_reg, height_reg, thresh_reg;

    // traffic shaping
    int          send_idle_pct = 29;
    int          recv_idle_pct = 64;
    int          recv_hold_left = 0;
    int          cycles = 0;
    int          mismatches = 0;
    int          base_level;
    int          phase_words;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic void clear_position();
        in_col = 0;
        in_row = 0;
        out_idx = 0;
        outlier_sum = '0;
    endfunction

    function automatic void apply_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_WIDTH: begin
                width_reg = 32'(data[8:0]);
                clear_position();
            end
            CFG_HEIGHT: begin
                height_reg = 32'(data[8:0]);
                clear_position();
            end
            CFG_THRESH: begin
                thresh_reg = 32'(data);
            end
            default: ;
        endcase
    endfunction

    // advance the window by one word unless it is an early flush; returns 1 when a bin gets decided
    function automatic bit decide_bin(bin_word_t wd, output t_result res);
        int unsigned w, h, n, pos, c, x, y, nv, med, contrib;
        logic [15:0] vals [9];
        logic [15:0] v, t, hv;
        bit outl, is_last;
        int k;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        n = w * h;
        pos = in_row * w + in_col;
        res = '0;
        // flush before the histogram is complete does nothing
        if (pos < n && wd.action == ACT_FLUSH) return 0;
        v = (pos >= n) ? 16'd0 : wd.count;
        c = in_col % 256;
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = upper_mem[c];
        win[1][2] = middle_mem[c];
        win[2][2] = v;
        upper_mem[c] = middle_mem[c];
        middle_mem[c] = v;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < w + 1) return 0;

        x = out_idx % w;
        y = out_idx / w;
        nv = 0;
        // only in-bounds neighbors take part in the median
        for (int r = 0; r < 3; r++) begin
            if (r == 0 && y == 0) continue;
            if (r == 2 && y + 1 >= h) continue;
            for (int q = 0; q < 3; q++) begin
                if (q == 0 && x == 0) continue;
                if (q == 2 && x + 1 >= w) continue;
                vals[nv] = win[r][q];
                nv++;
            end
        end
        for (int r = 1; r < nv; r++) begin
            t = vals[r];
            k = r;
            while (k > 0 && vals[k-1] > t) begin
                vals[k] = vals[k-1];
                k--;
            end
            vals[k] = t;
        end
        med = 32'(vals[nv/2]);   // upper middle for even counts
        hv = win[1][1];
        outl = (32'(hv) < thresh_reg) && (32'(hv) > med);
        contrib = outl ? 32'(hv) : 32'd0;
        if (longint'(outlier_sum) + contrib > 64'hFFFF_FFFF) outlier_sum = '1;
        else outlier_sum = outlier_sum + contrib;
        is_last = (out_idx == n - 1);

        res.bin_x = x[7:0];
        res.bin_y = y[7:0];
        res.is_outlier = outl;
        res.outlier_count = contrib[15:0];
        res.running_total = outlier_sum;
        res.last_bin = is_last;
        if (is_last) clear_position();
        else out_idx++;
        return 1;
    endfunction

    // input driver: one word per handshake, idles at the chosen rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (decide_bin(word_on_bus, decided)) owed_results.push_back(decided);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    word_on_bus = pending_words.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.action <= word_on_bus.action;
                    in_ch.bin_count <= word_on_bus.count;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and checker; also owns the timeout
    always @(posedge i_clk) begin
        t_result exp_r;
        bit bad;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("histogram_outlier_bin_detector_unit verification failed");
            $finish;
        end else if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: x=%0d y=%0d",
                                 out_ch.bin_x, out_ch.bin_y);
                end else begin
                    exp_r = owed_results.pop_front();
                    bad = (out_ch.bin_x !== exp_r.bin_x)
                        | (out_ch.bin_y !== exp_r.bin_y)
                        | (out_ch.is_outlier !== exp_r.is_outlier)
                        | (out_ch.outlier_count !== exp_r.outlier_count)
                        | (out_ch.running_total !== exp_r.running_total)
                        | (out_ch.last_bin !== exp_r.last_bin);
                    if (bad) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("mismatch: exp x=%0d y=%0d o=%0b c=%0d t=%0d l=%0b",
                                exp_r.bin_x, exp_r.bin_y, exp_r.is_outlier,
                                exp_r.outlier_count, exp_r.running_total, exp_r.last_bin);
                            $display(", got x=%0d y=%0d o=%0b c=%0d t=%0d l=%0b",
                                out_ch.bin_x, out_ch.bin_y, out_ch.is_outlier,
                                out_ch.outlier_count, out_ch.running_total, out_ch.last_bin);
                        end
                    end
                end
            end
            // long hold-off lets the block fill up and push back on its input
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    // waits until every word is sent and every owed result is back, then lets the block settle
    task automatic wait_idle();
        while (pending_words.size() > 0 || in_ch.valid || owed_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    function automatic bit [15:0] pick_count();
        case ($urandom_range(7))
            0: return 16'($urandom_range(65535));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            2: return 16'($urandom_range(base_level + 3000));
            default: return 16'(base_level + $urandom_range(20));
        endcase
    endfunction

    function automatic void push_word(bit act, bit [15:0] cnt);
        bin_word_t wd;
        wd.action = act;
        wd.count = cnt;
        pending_words.push_back(wd);
        phase_words++;
    endfunction

    // one complete histogram plus the tail that drains it, sometimes led by early flush words
    function automatic void queue_histogram(int unsigned w, int unsigned h);
        base_level = $urandom_range(2000);
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 2)) push_word(ACT_FLUSH, 16'($urandom_range(65535)));
        end
        repeat (w * h) push_word(ACT_BIN, pick_count());
        // extra bins after the end count as flush words
        repeat (w + 1) push_word(1'($urandom_range(1)), 16'($urandom_range(65535)));
    endfunction

    task automatic random_histogram();
        int unsigned wr, hr, thr;
        case ($urandom_range(19))
            0: begin wr = $urandom_range(1) ? 256 : $urandom_range(257, 511); hr = 1; end
            1: begin wr = 1; hr = $urandom_range(1) ? 256 : $urandom_range(257, 511); end
            2: begin wr = 0; hr = $urandom_range(0, 4); end
            default: begin wr = $urandom_range(1, 8); hr = $urandom_range(1, 8); end
        endcase
        write_reg(CFG_WIDTH, CFG_W'(wr));
        write_reg(CFG_HEIGHT, CFG_W'(hr));
        if ($urandom_range(1)) begin
            case ($urandom_range(4))
                0: thr = 0;
                1: thr = 65536;
                2: thr = 131071;
                default: thr = $urandom_range(4000);
            endcase
            write_reg(CFG_THRESH, CFG_W'(thr));
        end
        queue_histogram(clamp_dim(wr), clamp_dim(hr));
        wait_idle();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_BIN;
        in_ch.bin_count = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_WIDTH;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        for (int i = 0; i < 256; i++) begin
            upper_mem[i] = '0;
            middle_mem[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int q = 0; q < 3; q++) win[r][q] = '0;
        width_reg = 256;
        height_reg = 256;
        thresh_reg = 655;
        clear_position();
        phase_words = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 3x3 with a spike in the middle, a saturated corner, a zero
        write_reg(CFG_WIDTH, CFG_W'(3));
        write_reg(CFG_HEIGHT, CFG_W'(3));
        write_reg(CFG_THRESH, CFG_W'(1000));
        push_word(ACT_FLUSH, 16'd7);            // early flush is ignored
        push_word(ACT_BIN, 16'd0);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_BIN, 16'hFFFF);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_BIN, 16'd500);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_BIN, 16'd10);
        push_word(ACT_FLUSH, 16'd0);
        push_word(ACT_BIN, 16'hFFFF);           // bin past the end acts as flush
        push_word(ACT_FLUSH, 16'd0);
        push_word(ACT_FLUSH, 16'd0);
        wait_idle();
        // single bin, zero threshold
        write_reg(CFG_WIDTH, CFG_W'(1));
        write_reg(CFG_HEIGHT, CFG_W'(1));
        write_reg(CFG_THRESH, CFG_W'(0));
        push_word(ACT_BIN, 16'hFFFF);
        push_word(ACT_FLUSH, 16'd0);
        push_word(ACT_FLUSH, 16'd0);
        wait_idle();
        // zero sizes act as one; even-count edge medians on a 2x2
        write_reg(CFG_WIDTH, CFG_W'(0));
        write_reg(CFG_HEIGHT, CFG_W'(0));
        write_reg(CFG_THRESH, CFG_W'(131071));
        push_word(ACT_BIN, 16'h8000);
        push_word(ACT_FLUSH, 16'd0);
        push_word(ACT_FLUSH, 16'd0);
        wait_idle();
        write_reg(CFG_WIDTH, CFG_W'(2));
        write_reg(CFG_HEIGHT, CFG_W'(2));
        push_word(ACT_BIN, 16'd1);
        push_word(ACT_BIN, 16'd40);
        push_word(ACT_BIN, 16'd2);
        push_word(ACT_BIN, 16'd3);
        repeat (3) push_word(ACT_FLUSH, 16'd0);
        wait_idle();
        // receiver holds off while a 6x6 histogram keeps coming
        write_reg(CFG_WIDTH, CFG_W'(6));
        write_reg(CFG_HEIGHT, CFG_W'(6));
        write_reg(CFG_THRESH, CFG_W'(1500));
        recv_hold_left = 300;
        queue_histogram(6, 6);
        wait_idle();

        // random phases: sender/receiver idle 29/64, then 64/29, then none
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 29 : (p == 1) ? 64 : 0;
            recv_idle_pct = (p == 0) ? 64 : (p == 1) ? 29 : 0;
            phase_words = 0;
            while (phase_words < 430) random_histogram();
        end

        wait_idle();
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("histogram_outlier_bin_detector_unit verification clean");
        end else begin
            $display("histogram_outlier_bin_detector_unit verification failed");
        end
        $finish;
    end

endmodule

/* histogram_outlier_bin_detector_unit.f */
sv/hobd_pkg.sv
sv/hobd_if.sv
sv/hobd_line_store.sv
sv/hobd_median9.sv
sv/hobd_out_fifo.sv
sv/histogram_outlier_bin_detector_unit.sv
tb/sv/histogram_outlier_bin_detector_unit_test.sv
